[hdl/extended_gcd_table_defines.svh]
// ------------------------------------------------------------------------
// extended_gcd_table_defines
// assertion macros shared by the extended gcd table design
// ------------------------------------------------------------------------
`ifndef EXTENDED_GCD_TABLE_DEFINES_SVH
`define EXTENDED_GCD_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EGCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define EGCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/egcd_pkg.sv]
// ------------------------------------------------------------------------
// egcd_pkg
// widths, limits and control types for the extended gcd table
// ------------------------------------------------------------------------
package egcd_pkg;

    // operand bits used (8 to 32)
    localparam int OP_W      = 32;
    // fixed field widths of the stream beats
    localparam int FIELD_W   = 32;
    localparam int COEF_W    = 33;
    localparam int S_DATA_W  = 2 * FIELD_W;
    localparam int M_USED_W  = 2 * FIELD_W + 2 * COEF_W;
    localparam int M_DATA_W  = ((M_USED_W + 7) / 8) * 8;
    localparam int PAD_W     = M_DATA_W - M_USED_W;

    // table length limit
    localparam int MAX_ROWS  = 64;
    localparam int ROW_CNT_W = $clog2(MAX_ROWS);
    localparam int BIT_CNT_W = $clog2(OP_W);

    // control for one serial division step
    typedef struct packed {
        logic start;
        logic step;
    } t_step_ctl;

endpackage

[hdl/egcd_div.sv]
// ------------------------------------------------------------------------
// egcd_div
// radix-2 restoring divider, msb first, one quotient bit per cycle on step
// ------------------------------------------------------------------------
module egcd_div (
    input  logic                        i_clk,
    input  egcd_pkg::t_step_ctl         i_ctl,
    input  logic [egcd_pkg::OP_W-1:0]   i_dividend,
    input  logic [egcd_pkg::OP_W-1:0]   i_divisor,
    output logic                        o_qbit,
    output logic [egcd_pkg::OP_W-1:0]   o_quotient,
    output logic [egcd_pkg::OP_W-1:0]   o_remainder
);

    logic [egcd_pkg::OP_W-1:0] r_quo;
    logic [egcd_pkg::OP_W-1:0] r_rem;
    logic [egcd_pkg::OP_W-1:0] r_dsr;
    logic [egcd_pkg::OP_W:0]   w_trial;
    logic [egcd_pkg::OP_W+1:0] w_diff;
    logic [egcd_pkg::OP_W-1:0] n_rem;

    // trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        w_trial = {r_rem, r_quo[egcd_pkg::OP_W-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_dsr};
        o_qbit  = ~w_diff[egcd_pkg::OP_W+1];
        n_rem   = o_qbit ? w_diff[egcd_pkg::OP_W-1:0] : w_trial[egcd_pkg::OP_W-1:0];
    end

    // dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (i_ctl.step) begin
            r_quo <= {r_quo[egcd_pkg::OP_W-2:0], o_qbit};
            r_rem <= n_rem;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[hdl/egcd_mac.sv]
// ------------------------------------------------------------------------
// egcd_mac
// serial multiply-subtract: older - q * newer, q taken one bit a cycle on step
// ------------------------------------------------------------------------
module egcd_mac (
    input  logic                          i_clk,
    input  egcd_pkg::t_step_ctl           i_ctl,
    input  logic                          i_qbit,
    input  logic [egcd_pkg::COEF_W-1:0]   i_newer,
    input  logic [egcd_pkg::COEF_W-1:0]   i_older,
    output logic [egcd_pkg::COEF_W-1:0]   o_next
);

    logic [egcd_pkg::COEF_W-1:0] r_acc;

    // horner accumulation of q * newer, msb of q first, wraps at coefficient width
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc <= '0;
        end else if (i_ctl.step) begin
            r_acc <= {r_acc[egcd_pkg::COEF_W-2:0], 1'b0} + (i_qbit ? i_newer : '0);
        end
    end

    assign o_next = i_older - r_acc;

endmodule

[hdl/extended_gcd_table.sv]
// ------------------------------------------------------------------------
// extended_gcd_table
// extended euclidean algorithm, full table streamed one row per beat
// ------------------------------------------------------------------------
// usage
//   slave side: one beat carries operands a (tdata[31:0]) and b (tdata[63:32]).
//   master side: one beat per table row; tlast marks the final row and
//   tuser is the coefficient valid flag.
//   rows: (a,0,1,0), (b,0,0,1), then one per division step up to a zero
//   remainder row or MAX_ROWS rows; b of zero gives the first two only.
// sequence
//   after the operand beat the first row is loaded into the output
//   register in S_ROW0, the second in S_ROW1. each division step then
//   passes S_LOAD (divider and multipliers start), S_DIV (the bit-serial
//   divider runs) and S_EMIT (the row goes to the output register).
//   one table is worked at a time: tready is high only between tables.
// reset and stall
//   reset drops master tvalid and returns to idle. a stalled master
//   side holds the row in the output register and the sequencer waits to load the next.
// ------------------------------------------------------------------------
`include "extended_gcd_table_defines.svh"

module extended_gcd_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side, tdata: operand_a, operand_b
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [egcd_pkg::S_DATA_W-1:0]     i_s_tdata,
    // master side, tdata: remainder, quotient, coeff_x, coeff_y, zero pad
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [egcd_pkg::M_DATA_W-1:0]     o_m_tdata,
    // tuser: coeff_valid
    output logic                              o_m_tuser,
    // tlast: last_row
    output logic                              o_m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW0,
        S_ROW1,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                              r_state;
    logic [egcd_pkg::OP_W-1:0]           r_dividend;
    logic [egcd_pkg::OP_W-1:0]           r_divisor;
    logic [egcd_pkg::COEF_W-1:0]         r_x_older;
    logic [egcd_pkg::COEF_W-1:0]         r_x_newer;
    logic [egcd_pkg::COEF_W-1:0]         r_y_older;
    logic [egcd_pkg::COEF_W-1:0]         r_y_newer;
    logic [egcd_pkg::ROW_CNT_W-1:0]      r_row_cnt;
    logic [egcd_pkg::BIT_CNT_W-1:0]      r_bit_cnt;
    logic                                r_m_valid;
    logic [egcd_pkg::M_DATA_W-1:0]       r_m_data;
    logic                                r_m_user;
    logic                                r_m_last;

    egcd_pkg::t_step_ctl                 w_ctl;
    logic                                w_qbit;
    logic [egcd_pkg::OP_W-1:0]           w_quo;
    logic [egcd_pkg::OP_W-1:0]           w_rem;
    logic [egcd_pkg::COEF_W-1:0]         w_nx;
    logic [egcd_pkg::COEF_W-1:0]         w_ny;
    logic                                w_out_free;
    logic                                w_emit;
    logic                                w_in_beat;
    logic                                w_final;
    logic [egcd_pkg::OP_W-1:0]           w_op_a;
    logic [egcd_pkg::OP_W-1:0]           w_op_b;

    // handshake and step control
    always_comb begin
        w_ctl.start = (r_state == S_LOAD);
        w_ctl.step  = (r_state == S_DIV);
        w_out_free  = ~r_m_valid | i_m_tready;
        w_emit      = w_out_free && (r_state inside {S_ROW0, S_ROW1, S_EMIT});
        w_in_beat   = i_s_tvalid & (r_state == S_IDLE);
        w_final     = (w_rem == '0)
                    || (r_row_cnt == egcd_pkg::ROW_CNT_W'(egcd_pkg::MAX_ROWS - 1));
        w_op_a      = i_s_tdata[egcd_pkg::OP_W-1:0];
        w_op_b      = i_s_tdata[egcd_pkg::FIELD_W +: egcd_pkg::OP_W];
    end

    egcd_div u_div (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_dividend  (r_dividend),
        .i_divisor   (r_divisor),
        .o_qbit      (w_qbit),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    egcd_mac u_mac_x (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_qbit  (w_qbit),
        .i_newer (r_x_newer),
        .i_older (r_x_older),
        .o_next  (w_nx)
    );

    egcd_mac u_mac_y (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_qbit  (w_qbit),
        .i_newer (r_y_newer),
        .i_older (r_y_older),
        .o_next  (w_ny)
    );

    // sequencer, table state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_valid  <= 1'b0;
            r_dividend <= '0;
            r_divisor  <= '0;
            r_x_older  <= '0;
            r_x_newer  <= '0;
            r_y_older  <= '0;
            r_y_newer  <= '0;
        end else begin
            // output beat taken and no new row loaded this cycle
            if (r_m_valid && i_m_tready && !w_emit) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_dividend <= w_op_a;
                        r_divisor  <= w_op_b;
                        r_x_older  <= egcd_pkg::COEF_W'(1);
                        r_x_newer  <= '0;
                        r_y_older  <= '0;
                        r_y_newer  <= egcd_pkg::COEF_W'(1);
                        r_state    <= S_ROW0;
                    end
                end
                S_ROW0: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {{egcd_pkg::PAD_W{1'b0}}, r_y_older, r_x_older,
                                      {egcd_pkg::FIELD_W{1'b0}},
                                      egcd_pkg::FIELD_W'(r_dividend)};
                        r_m_user  <= 1'b1;
                        r_m_last  <= 1'b0;
                        r_state   <= S_ROW1;
                    end
                end
                S_ROW1: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {{egcd_pkg::PAD_W{1'b0}}, r_y_newer, r_x_newer,
                                      {egcd_pkg::FIELD_W{1'b0}},
                                      egcd_pkg::FIELD_W'(r_divisor)};
                        r_m_user  <= 1'b1;
                        r_m_last  <= (r_divisor == '0);
                        r_row_cnt <= egcd_pkg::ROW_CNT_W'(2);
                        r_state   <= (r_divisor == '0) ? S_IDLE : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_bit_cnt <= egcd_pkg::BIT_CNT_W'(egcd_pkg::OP_W - 1);
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_bit_cnt <= r_bit_cnt - 1'b1;
                    if (r_bit_cnt == '0) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        if (w_final) begin
                            // closing row: coefficients null
                            r_m_data <= {{egcd_pkg::PAD_W{1'b0}},
                                         {egcd_pkg::COEF_W{1'b0}},
                                         {egcd_pkg::COEF_W{1'b0}},
                                         egcd_pkg::FIELD_W'(w_quo),
                                         egcd_pkg::FIELD_W'(w_rem)};
                            r_m_user <= 1'b0;
                            r_m_last <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_m_data   <= {{egcd_pkg::PAD_W{1'b0}}, w_ny, w_nx,
                                           egcd_pkg::FIELD_W'(w_quo),
                                           egcd_pkg::FIELD_W'(w_rem)};
                            r_m_user   <= 1'b1;
                            r_m_last   <= 1'b0;
                            r_x_older  <= r_x_newer;
                            r_x_newer  <= w_nx;
                            r_y_older  <= r_y_newer;
                            r_y_newer  <= w_ny;
                            r_dividend <= r_divisor;
                            r_divisor  <= w_rem;
                            r_row_cnt  <= r_row_cnt + 1'b1;
                            r_state    <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

    // checks
    `EGCD_ASSERT_NEXT(a_start_table, i_s_tvalid && o_s_tready, r_state == S_ROW0,
        "operand beat did not start a table")
    `EGCD_ASSERT_NOW(a_null_only_last, o_m_tvalid && !o_m_tuser, o_m_tlast,
        "null coefficients on a row that is not the last")
    `EGCD_ASSERT_NOW(a_null_coeffs_zero, o_m_tvalid && !o_m_tuser,
        o_m_tdata[egcd_pkg::M_USED_W-1:2*egcd_pkg::FIELD_W] == '0,
        "closing row carries nonzero coefficients")
    `EGCD_ASSERT_NOW(a_divisor_nonzero, r_state == S_LOAD || r_state == S_DIV,
        r_divisor != '0, "division started with a zero divisor")

endmodule

[bench/extended_gcd_table_check.sv]
// ------------------------------------------------------------------------
// extended_gcd_table_check
// watches both stream channels of the extended gcd table, builds the
// expected table for every operand beat and compares each row beat with
// the oldest expected row, field by field
// ------------------------------------------------------------------------
module extended_gcd_table_check
    import egcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // operand channel, tdata: operand_a, operand_b
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [S_DATA_W-1:0]   i_s_tdata,
    // row channel, tdata: remainder, quotient, coeff_x, coeff_y, zero pad
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_DATA_W-1:0]   i_m_tdata,
    // tuser: coeff_valid
    input  logic                  i_m_tuser,
    // tlast: last_row
    input  logic                  i_m_tlast,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // one row of the euclid table
    typedef struct packed {
        logic [FIELD_W-1:0] remainder;
        logic [FIELD_W-1:0] quotient;
        logic [COEF_W-1:0]  coeff_x;
        logic [COEF_W-1:0]  coeff_y;
        logic               coeff_valid;
        logic               last_row;
    } t_row;

    t_row table_rows_q[$];
    int   mismatch_count = 0;

    assign o_errors = mismatch_count;

    // append one expected row at the tail
    function automatic void append_row(input t_row row);
        table_rows_q.insert(table_rows_q.size(), row);
    endfunction

    // expected rows of the whole table for operands a and b
    function automatic void queue_euclid_table(input logic [FIELD_W-1:0] a_in,
                                               input logic [FIELD_W-1:0] b_in);
        logic [63:0]        op_mask;
        logic [FIELD_W-1:0] a, b, dividend, divisor, quo, rem;
        logic [COEF_W-1:0]  x_old, x_new, y_old, y_new, x_next, y_next;
        int                 rows;
        op_mask = (64'd1 << OP_W) - 64'd1;
        a = a_in & op_mask[FIELD_W-1:0];
        b = b_in & op_mask[FIELD_W-1:0];
        append_row(t_row'{a, '0, 33'd1, 33'd0, 1'b1, 1'b0});
        append_row(t_row'{b, '0, 33'd0, 33'd1, 1'b1, b == '0});
        if (b == '0)
            return;
        dividend = a;
        divisor  = b;
        x_old = 33'd1;
        x_new = 33'd0;
        y_old = 33'd0;
        y_new = 33'd1;
        for (rows = 2; rows < MAX_ROWS; rows++) begin
            quo = dividend / divisor;
            rem = dividend % divisor;
            // zero remainder or the row limit closes the table
            if (rem == '0 || rows == MAX_ROWS - 1) begin
                append_row(t_row'{rem, quo, 33'd0, 33'd0, 1'b0, 1'b1});
                break;
            end
            // coefficients wrap modulo 2^33
            x_next = x_old - quo * x_new;
            y_next = y_old - quo * y_new;
            append_row(t_row'{rem, quo, x_next, y_next, 1'b1, 1'b0});
            x_old    = x_new;
            x_new    = x_next;
            y_old    = y_new;
            y_new    = y_next;
            dividend = divisor;
            divisor  = rem;
        end
    endfunction

    // sample both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_row want;
        t_row got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                queue_euclid_table(i_s_tdata[FIELD_W-1:0],
                                   i_s_tdata[2*FIELD_W-1:FIELD_W]);
            if (i_m_tvalid && i_m_tready) begin
                got.remainder   = i_m_tdata[FIELD_W-1:0];
                got.quotient    = i_m_tdata[2*FIELD_W-1:FIELD_W];
                got.coeff_x     = i_m_tdata[2*FIELD_W+COEF_W-1:2*FIELD_W];
                got.coeff_y     = i_m_tdata[M_USED_W-1:2*FIELD_W+COEF_W];
                got.coeff_valid = i_m_tuser;
                got.last_row    = i_m_tlast;
                if (table_rows_q.size() == 0) begin
                    $error("row beat with nothing expected: remainder %0h quotient %0h",
                           got.remainder, got.quotient);
                    mismatch_count++;
                end else begin
                    want = table_rows_q.pop_front();
                    if (got.remainder !== want.remainder) begin
                        $error("remainder: expected %0h, actual %0h",
                               want.remainder, got.remainder);
                        mismatch_count++;
                    end
                    if (got.quotient !== want.quotient) begin
                        $error("quotient: expected %0h, actual %0h",
                               want.quotient, got.quotient);
                        mismatch_count++;
                    end
                    if (got.coeff_x !== want.coeff_x) begin
                        $error("coeff_x: expected %0h, actual %0h",
                               want.coeff_x, got.coeff_x);
                        mismatch_count++;
                    end
                    if (got.coeff_y !== want.coeff_y) begin
                        $error("coeff_y: expected %0h, actual %0h",
                               want.coeff_y, got.coeff_y);
                        mismatch_count++;
                    end
                    if (got.coeff_valid !== want.coeff_valid) begin
                        $error("coeff_valid: expected %0b, actual %0b",
                               want.coeff_valid, got.coeff_valid);
                        mismatch_count++;
                    end
                    if (got.last_row !== want.last_row) begin
                        $error("last_row: expected %0b, actual %0b",
                               want.last_row, got.last_row);
                        mismatch_count++;
                    end
                end
            end
        end
        o_pending <= table_rows_q.size();
    end

endmodule

[bench/extended_gcd_table_test.sv]
// ------------------------------------------------------------------------
// extended_gcd_table_test
// drives operand pairs into the extended gcd table: a directed set of
// edge cases, then random pairs of mixed magnitude, long fibonacci chains
// and zero divisors, with random idle bursts on both channels; the
// checker predicts and compares every row
// ------------------------------------------------------------------------
module extended_gcd_table_test;
    import egcd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PAIRS = 270;
    localparam int QUIET_PAIRS  = 30;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    int                  errors;
    int                  pending;
    bit                  quiet = 1'b0;

    extended_gcd_table uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    extended_gcd_table_check checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tlast  (m_tlast),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // row channel back-pressure in random bursts
    initial begin : row_stall
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_tready   = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // cycles in a row with no beat on either channel
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[extended_gcd_table] ERROR");
                $finish;
            end
        end
    end

    // one operand beat, with an optional idle burst ahead of it
    task automatic send_operands(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {b, a};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // consecutive fibonacci numbers give the longest tables
    task automatic send_fibonacci(input int steps, input bit swap);
        logic [FIELD_W-1:0] f_lo, f_hi, f_next;
        f_lo = 32'd1;
        f_hi = 32'd1;
        repeat (steps) begin
            f_next = f_lo + f_hi;
            f_lo   = f_hi;
            f_hi   = f_next;
        end
        if (swap)
            send_operands(f_lo, f_hi);
        else
            send_operands(f_hi, f_lo);
    endtask

    // random pair drawn from a mix of shapes
    task automatic send_random_pair();
        logic [FIELD_W-1:0] a, b;
        case ($urandom_range(0, 9))
            0, 1: begin
                a = $urandom;
                b = $urandom;
            end
            2, 3: begin
                a = $urandom >> $urandom_range(0, 31);
                b = $urandom >> $urandom_range(0, 31);
            end
            4: begin
                // divisor zero
                a = $urandom >> $urandom_range(0, 31);
                b = '0;
            end
            5: begin
                a = $urandom_range(0, 100);
                b = $urandom_range(0, 100);
            end
            6: begin
                // exact multiple
                b = ($urandom >> $urandom_range(8, 31)) | 32'd1;
                a = b * $urandom_range(1, 300);
            end
            default: begin
                send_fibonacci($urandom_range(2, 45), $urandom_range(0, 1));
                return;
            end
        endcase
        send_operands(a, b);
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed edge cases
        send_operands(32'd0, 32'd0);
        send_operands(32'd0, 32'd5);
        send_operands(32'd5, 32'd0);
        send_operands(32'hFFFF_FFFF, 32'd0);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'd1);
        send_operands(32'd1, 32'hFFFF_FFFF);
        send_operands(32'd1, 32'd1);
        send_operands(32'd12, 32'd18);
        send_operands(32'd240, 32'd46);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_operands(32'h8000_0000, 32'h7FFF_FFFF);
        send_operands(32'hAAAA_AAAA, 32'h5555_5555);
        send_operands(32'h5555_5555, 32'hAAAA_AAAA);
        send_operands(32'd3, 32'h8000_0000);
        send_operands(32'd1000, 32'd1000);
        send_operands(32'hFFFF_FFFF, 32'h0001_0000);
        send_fibonacci(45, 1'b0);
        send_fibonacci(45, 1'b1);
        send_fibonacci(44, 1'b0);

        // random pairs, the last stretch without idling
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n == RANDOM_PAIRS - QUIET_PAIRS)
                quiet = 1'b1;
            send_random_pair();
        end
        s_tvalid = 1'b0;

        // drain the remaining rows, then watch for stray beats
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && pending == 0)
            $display("[extended_gcd_table] OK");
        else
            $display("[extended_gcd_table] ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/egcd_pkg.sv
hdl/egcd_div.sv
hdl/egcd_mac.sv
hdl/extended_gcd_table.sv
bench/extended_gcd_table_check.sv
bench/extended_gcd_table_test.sv
